// ----- rtl/egcd_pkg.sv -----
// egcd_pkg: shared types for the extended gcd block
// controller states plus the command and status bundles between
// controller and datapath; no dependencies
package egcd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FIX,
      ST_UPD,
      ST_OUT
   } state_type;

   // one-hot style commands from controller to datapath
   typedef struct packed {
      logic load;       // capture operands, init coefficient pairs
      logic prep;       // take magnitudes, clear divider
      logic step;       // one restoring division bit
      logic fix;        // euclidean remainder fixup, fold adjust into c1
      logic upd;        // coefficient update and operand shift
      logic out_write;  // load the result register
   } cmd_type;

   typedef struct packed {
      logic b_zero;     // current divisor is zero
      logic rem_zero;   // remainder of the step just done is zero
      logic out_free;   // result register can take a beat this cycle
   } status_type;

endpackage

// ----- rtl/egcd_if.sv -----
// egcd_if: valid/ready channel interfaces for the extended gcd block
// request carries the two operands, response carries gcd and coefficients
// no dependencies
interface egcd_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] operand_a;
   logic signed [DATA_WIDTH-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] gcd_value;
   logic signed [DATA_WIDTH-1:0] coef_a;
   logic signed [DATA_WIDTH-1:0] coef_b;
   logic                         zero_divisor;

   modport source (output valid, output gcd_value, output coef_a, output coef_b,
                   output zero_divisor, input ready);
   modport sink (input valid, input gcd_value, input coef_a, input coef_b,
                 input zero_divisor, output ready);
endinterface

// ----- rtl/egcd_datapath.sv -----
// egcd_datapath: operand, coefficient and divider registers plus result register
// driven by egcd_controller commands; uses egcd_pkg
module egcd_datapath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  egcd_pkg::cmd_type            cmd,
   output egcd_pkg::status_type         status,
   input  logic signed [DATA_WIDTH-1:0] req_a,
   input  logic signed [DATA_WIDTH-1:0] req_b,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_gcd,
   output logic signed [DATA_WIDTH-1:0] rsp_coef_a,
   output logic signed [DATA_WIDTH-1:0] rsp_coef_b,
   output logic                         rsp_zero_div
);

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] ONE = W'(1);

   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [W-1:0] c1x_ff, c1x_in, c1y_ff, c1y_in;
   logic [W-1:0] c2x_ff, c2x_in, c2y_ff, c2y_in;
   logic [W-1:0] rem_ff, rem_in, dvd_ff, dvd_in, bmag_ff, bmag_in;
   logic [W-1:0] px_ff, px_in, py_ff, py_in;
   logic         an_ff, an_in, bn_ff, bn_in, err_ff, err_in;
   logic [W-1:0] gcd_ff, gcd_in, ca_ff, ca_in, cb_ff, cb_in;
   logic         zd_ff, zd_in, valid_ff, valid_in;

   logic [W:0]   trial;
   logic [W-1:0] diff;
   logic         ge, adj, sneg;

   always_comb begin
      trial = {rem_ff, dvd_ff[W-1]};
      diff  = trial[W-1:0] - bmag_ff;
      ge    = (trial >= {1'b0, bmag_ff});
      adj   = an_ff && (rem_ff != '0);
      sneg  = an_ff ^ bn_ff;
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      c1x_in  = c1x_ff;
      c1y_in  = c1y_ff;
      c2x_in  = c2x_ff;
      c2y_in  = c2y_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      bmag_in = bmag_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      an_in   = an_ff;
      bn_in   = bn_ff;
      err_in  = err_ff;
      gcd_in  = gcd_ff;
      ca_in   = ca_ff;
      cb_in   = cb_ff;
      zd_in   = zd_ff;
      valid_in = valid_ff;

      if (cmd.load) begin
         a_in   = W'(req_a);
         b_in   = W'(req_b);
         c1x_in = ONE;
         c1y_in = '0;
         c2x_in = '0;
         c2y_in = ONE;
         err_in = (req_b == '0);
      end

      if (cmd.prep) begin
         an_in   = a_ff[W-1];
         bn_in   = b_ff[W-1];
         dvd_in  = a_ff[W-1] ? (~a_ff + ONE) : a_ff;
         bmag_in = b_ff[W-1] ? (~b_ff + ONE) : b_ff;
         rem_in  = '0;
         px_in   = '0;
         py_in   = '0;
      end

      // restoring division, quotient bits fed msb first into q*c2 accumulators
      if (cmd.step) begin
         rem_in = ge ? diff : trial[W-1:0];
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         px_in  = {px_ff[W-2:0], 1'b0} + (ge ? c2x_ff : '0);
         py_in  = {py_ff[W-2:0], 1'b0} + (ge ? c2y_ff : '0);
      end

      // negative dividend with nonzero remainder: quotient moves by one
      if (cmd.fix && adj) begin
         rem_in = bmag_ff - rem_ff;
         c1x_in = bn_ff ? (c1x_ff - c2x_ff) : (c1x_ff + c2x_ff);
         c1y_in = bn_ff ? (c1y_ff - c2y_ff) : (c1y_ff + c2y_ff);
      end

      if (cmd.upd) begin
         c2x_in = sneg ? (c1x_ff + px_ff) : (c1x_ff - px_ff);
         c2y_in = sneg ? (c1y_ff + py_ff) : (c1y_ff - py_ff);
         c1x_in = c2x_ff;
         c1y_in = c2y_ff;
         a_in   = b_ff;
         b_in   = rem_ff;
      end

      if (cmd.out_write) begin
         valid_in = 1'b1;
         gcd_in   = err_ff ? '0 : a_ff;
         ca_in    = err_ff ? '0 : c1x_ff;
         cb_in    = err_ff ? '0 : c1y_ff;
         zd_in    = err_ff;
      end else if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c1x_ff  <= c1x_in;
      c1y_ff  <= c1y_in;
      c2x_ff  <= c2x_in;
      c2y_ff  <= c2y_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      bmag_ff <= bmag_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      an_ff   <= an_in;
      bn_ff   <= bn_in;
      err_ff  <= err_in;
      gcd_ff  <= gcd_in;
      ca_ff   <= ca_in;
      cb_ff   <= cb_in;
      zd_ff   <= zd_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      status.b_zero   = (b_ff == '0);
      status.rem_zero = (rem_ff == '0);
      status.out_free = !valid_ff || rsp_ready;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_gcd      = $signed(gcd_ff);
   assign rsp_coef_a   = $signed(ca_ff);
   assign rsp_coef_b   = $signed(cb_ff);
   assign rsp_zero_div = zd_ff;

   // partial remainder stays below the divisor magnitude
   a_rem_step: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rem_ff < bmag_ff)
      else $error("remainder not below divisor after division step");

   a_rem_fix: assert property (@(posedge clock) disable iff (reset)
      cmd.fix |=> rem_ff < bmag_ff)
      else $error("remainder not below divisor after fixup");

   // a stalled response beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(gcd_ff) && $stable(zd_ff)))
      else $error("response beat changed while stalled");

endmodule

// ----- rtl/egcd_controller.sv -----
// egcd_controller: state machine sequencing check, divide, fixup and update
// issues egcd_pkg::cmd_type to the datapath and reads egcd_pkg::status_type
module egcd_controller #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  egcd_pkg::status_type    status,
   output egcd_pkg::cmd_type       cmd
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

   egcd_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= egcd_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         egcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = egcd_pkg::ST_CHECK;
            end
         end
         egcd_pkg::ST_CHECK: begin
            if (status.b_zero) begin
               state_in = egcd_pkg::ST_OUT;
            end else begin
               cmd.prep = 1'b1;
               count_in = '0;
               state_in = egcd_pkg::ST_DIV;
            end
         end
         egcd_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            if (count_ff == LAST) begin
               state_in = egcd_pkg::ST_FIX;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         egcd_pkg::ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = egcd_pkg::ST_UPD;
         end
         egcd_pkg::ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = status.rem_zero ? egcd_pkg::ST_OUT : egcd_pkg::ST_CHECK;
         end
         egcd_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_write = 1'b1;
               state_in      = egcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = egcd_pkg::ST_IDLE;
         end
      endcase
   end

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == egcd_pkg::ST_IDLE && req_valid) |=> state_ff == egcd_pkg::ST_CHECK)
      else $error("accepted beat did not start a check");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == egcd_pkg::ST_DIV && count_ff != LAST) |=> state_ff == egcd_pkg::ST_DIV)
      else $error("division left before all quotient bits");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |-> status.out_free)
      else $error("result register overwritten while holding a beat");

endmodule

// ----- rtl/extended_gcd_euclidean.sv -----
// extended_gcd_euclidean: gcd and bezout coefficients by euclid with euclidean division
// a zero divisor goes from check straight to output; else each euclid step runs check, divide, fixup and update
// (about 46 steps worst case at 32 bits); the divide phase takes one restoring divider bit per cycle
// flow: one item in flight; next request beat once the result register is written
// reset: synchronous active high, returns controller to idle and empties the output register
// uses egcd_pkg, egcd_if, egcd_controller, egcd_datapath
module extended_gcd_euclidean #(
   parameter int DATA_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   egcd_req_if.sink   req_chan,
   egcd_rsp_if.source rsp_chan
);

   // command and status between controller and datapath
   egcd_pkg::cmd_type    cmd;
   egcd_pkg::status_type status;

   // controller: idle, check divisor, divide bit by bit, fixup, update, output
   egcd_controller #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: operands, coefficient pairs, divider, q*c2 accumulators,
   // and the result register that holds a beat until the sink takes it
   egcd_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_a        (req_chan.operand_a),
      .req_b        (req_chan.operand_b),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_gcd      (rsp_chan.gcd_value),
      .rsp_coef_a   (rsp_chan.coef_a),
      .rsp_coef_b   (rsp_chan.coef_b),
      .rsp_zero_div (rsp_chan.zero_divisor)
   );

endmodule

// ----- test/extended_gcd_euclidean_test.sv -----
// extended_gcd_euclidean_test: self-checking bench for the extended gcd block
// predicts gcd and bezout coefficients per request beat and checks every response beat
// depends on rtl/egcd_pkg.sv, rtl/egcd_if.sv and rtl/extended_gcd_euclidean.sv
`timescale 1ns / 100ps

module extended_gcd_euclidean_test;

   localparam int W               = 32;
   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_PER_MIX  = 122;
   // settle time covers the longest correct item, about 46 euclid steps
   localparam int SETTLE_CYCLES   = 2 + 48 * (W + 3);
   localparam int HOLD_CYCLES     = 2000;
   localparam int WATCHDOG_LIMIT  = 20000;

   typedef logic [W-1:0] word_type;

   localparam word_type MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam word_type MOST_POS = {1'b0, {(W-1){1'b1}}};

   typedef struct {
      word_type gcd_value;
      word_type coef_a;
      word_type coef_b;
      logic     zero_divisor;
   } bezout_type;

   // keeps the predicted results in arrival order and checks responses against them
   class bezout_scoreboard_type;
      bezout_type  pending[$];
      int unsigned mismatches;
      int unsigned pairs_seen;
      int unsigned zero_divs;
      int unsigned exact_divs;

      // euclidean division, remainder never negative
      function void euclid_divide(input word_type num, input word_type den,
                                  output word_type quo, output word_type rem);
         logic     num_neg;
         logic     den_neg;
         word_type num_mag;
         word_type den_mag;
         word_type q_mag;
         word_type r_mag;
         num_neg = num[W-1];
         den_neg = den[W-1];
         num_mag = num_neg ? -num : num;
         den_mag = den_neg ? -den : den;
         if (den_mag == '0) begin
            quo = '0;
            rem = '0;
            return;
         end
         q_mag = num_mag / den_mag;
         r_mag = num_mag % den_mag;
         quo = (num_neg != den_neg) ? -q_mag : q_mag;
         if (num_neg && r_mag != '0) begin
            // step the quotient away from the divisor sign, lift the remainder
            quo = den_neg ? quo + 1'b1 : quo - 1'b1;
            rem = den_mag - r_mag;
         end else begin
            rem = r_mag;
         end
      endfunction

      function bezout_type bezout_of(input word_type a, input word_type b);
         bezout_type res;
         word_type   q, r, c1x, c1y, c2x, c2y, tx, ty;
         if (b == '0) begin
            res = '{gcd_value: '0, coef_a: '0, coef_b: '0, zero_divisor: 1'b1};
            zero_divs++;
            return res;
         end
         euclid_divide(a, b, q, r);
         if (r == '0) exact_divs++;
         c1x = '0;
         c1y = 1;
         c2x = 1;
         c2y = -q;
         a = b;
         b = r;
         while (r != '0) begin
            euclid_divide(a, b, q, r);
            tx  = c2x;
            ty  = c2y;
            c2x = c1x - q * c2x;
            c2y = c1y - q * c2y;
            c1x = tx;
            c1y = ty;
            a   = b;
            b   = r;
         end
         res = '{gcd_value: a, coef_a: c1x, coef_b: c1y, zero_divisor: 1'b0};
         return res;
      endfunction

      function void note_operands(input word_type a, input word_type b);
         pending.insert(pending.size(), bezout_of(a, b));
         pairs_seen++;
      endfunction

      function void check_result(input word_type gcd, input word_type ca, input word_type cb,
                                 input logic zd);
         bezout_type want;
         if (pending.size() == 0) begin
            $error("response beat with no request outstanding: gcd_value %0d",
                   $signed(gcd));
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (gcd !== want.gcd_value) begin
            $error("gcd_value: expected %0d, got %0d", $signed(want.gcd_value),
                   $signed(gcd));
            mismatches++;
         end
         if (ca !== want.coef_a) begin
            $error("coef_a: expected %0d, got %0d", $signed(want.coef_a), $signed(ca));
            mismatches++;
         end
         if (cb !== want.coef_b) begin
            $error("coef_b: expected %0d, got %0d", $signed(want.coef_b), $signed(cb));
            mismatches++;
         end
         if (zd !== want.zero_divisor) begin
            $error("zero_divisor: expected %0b, got %0b", want.zero_divisor, zd);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   egcd_req_if #(.DATA_WIDTH(W)) req_chan ();
   egcd_rsp_if #(.DATA_WIDTH(W)) rsp_chan ();

   extended_gcd_euclidean #(.DATA_WIDTH(W)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bezout_scoreboard_type sb = new;

   // idle odds in percent, set per phase by the main sequence
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   // raised by the main sequence, taken up by the response process
   bit          hold_request;

   word_type fib [0:46];

   // directed pairs: extremes, sign mixes of the remainder fixup, exact
   // division with a negative divisor, zero divisor, most negative over -1
   // and the fibonacci worst case for step count
   word_type dir_a [23] = '{
      MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG,
      -32'sd7, 32'sd7, -32'sd7, 32'sd0, 32'sd0, 32'sd12,
      -32'sd1, MOST_NEG, MOST_POS, 32'sd0,
      32'sd1836311903, -32'sd1836311903, 32'sd240, 32'sd5, -32'sd1,
      MOST_POS, MOST_NEG + 1
   };
   word_type dir_b [23] = '{
      -32'sd1, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, 32'sd1,
      32'sd3, -32'sd3, -32'sd3, 32'sd5, -32'sd5, -32'sd4,
      32'sd0, 32'sd0, 32'sd0, 32'sd0,
      32'sd1134903170, 32'sd1134903170, 32'sd46, MOST_NEG, -32'sd1,
      32'sd2, -32'sd2
   };

   always #(HALF_PERIOD) clock = ~clock;

   function automatic word_type corner_value();
      case ($urandom_range(5))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '1;
         3: return '0;
         4: return 1;
         default: return MOST_NEG + 1;
      endcase
   endfunction

   function automatic word_type maybe_negate(input word_type v);
      return $urandom_range(1) ? -v : v;
   endfunction

   // draws one operand pair from a mix of shapes
   task automatic next_operands(output word_type a, output word_type b);
      int unsigned pick;
      int unsigned n;
      word_type    k;
      pick = $urandom_range(99);
      if (pick < 35) begin
         // full width, every bit toggles
         a = $urandom;
         b = $urandom;
      end else if (pick < 50) begin
         a = $urandom_range(2000) - 1000;
         b = $urandom_range(2000) - 1000;
      end else if (pick < 62) begin
         // shared factor so the gcd is not trivially one
         k = $urandom_range(1, 1023);
         a = maybe_negate(k * $urandom_range(1 << 20));
         b = maybe_negate(k * $urandom_range(1, 1 << 20));
      end else if (pick < 72) begin
         // b divides a without wrap
         b = $urandom_range(1, 65535);
         a = maybe_negate(b * $urandom_range(32767));
         b = maybe_negate(b);
      end else if (pick < 78) begin
         a = $urandom;
         b = '0;
      end else if (pick < 84) begin
         // consecutive fibonacci numbers take the most steps
         n = $urandom_range(30, 45);
         a = maybe_negate(fib[n + 1]);
         b = maybe_negate(fib[n]);
      end else if (pick < 90) begin
         a = corner_value();
         b = corner_value();
      end else begin
         a = $urandom;
         b = maybe_negate($urandom_range(1, 255));
      end
   endtask

   // offers one request beat and returns at the edge where it is taken
   task automatic send_operands(input word_type a, input word_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_operands(a, b);
   endtask

   task automatic send_random(input int count);
      word_type a, b;
      repeat (count) begin
         next_operands(a, b);
         send_operands(a, b);
      end
   endtask

   // response side: check the beat taken at this edge, then pick ready for the next
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.gcd_value, rsp_chan.coef_a, rsp_chan.coef_b,
                            rsp_chan.zero_divisor);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            // long hold-off so the output register fills and the input backs up
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: counts edges with no beat on either channel
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a beat", quiet);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;
      hold_request       = 1'b0;
      send_idle_pct      = 30;
      recv_idle_pct      = 59;
      fib[0] = '0;
      fib[1] = 1;
      for (int i = 2; i <= 46; i++) fib[i] = fib[i-1] + fib[i-2];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender sparse-ish, receiver mostly stalled
      foreach (dir_a[i]) send_operands(dir_a[i], dir_b[i]);
      send_random(RANDOM_PER_MIX);

      // roles swapped
      send_idle_pct = 59;
      recv_idle_pct = 30;
      send_random(RANDOM_PER_MIX);

      // no idling, but open with a long response hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      send_random(RANDOM_PER_MIX);
      req_chan.valid <= 1'b0;

      // drain, then give a stray beat time to show up
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d operand pairs: %0d with a zero divisor, %0d dividing exactly",
               sb.pairs_seen, sb.zero_divs, sb.exact_divs);
      $display("idle mixes 30/59, 59/30 and none, plus a %0d-cycle response hold-off",
               HOLD_CYCLES);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/egcd_pkg.sv
rtl/egcd_if.sv
rtl/egcd_datapath.sv
rtl/egcd_controller.sv
rtl/extended_gcd_euclidean.sv
test/extended_gcd_euclidean_test.sv
